/* design/irc_pkg.sv */
`default_nettype none

package irc_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W  = 6;
  localparam int DEV_W   = 8;
  localparam int INUM_W  = 16;
  localparam int REF_W   = 16;
  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_MARK    = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REL_ZERO = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic look;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

/* design/irc_in_if.sv */
`default_nettype none

interface irc_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [irc_pkg::DEV_W-1:0]    dev;
  logic [irc_pkg::INUM_W-1:0]   inum;
  logic [irc_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, req_type, dev, inum, slot, input ready);
  modport sink   (input valid, req_type, dev, inum, slot, output ready);
endinterface

`default_nettype wire

/* design/irc_out_if.sv */
`default_nettype none

interface irc_out_if;
  logic                         valid;
  logic                         ready;
  logic [irc_pkg::SLOT_W-1:0]   slot_out;
  logic                         hit;
  logic                         loaded;
  logic [irc_pkg::REF_W-1:0]    ref_after;
  logic [1:0]                   status;

  modport source (output valid, slot_out, hit, loaded, ref_after, status, input ready);
  modport sink   (input valid, slot_out, hit, loaded, ref_after, status, output ready);
endinterface

`default_nettype wire

/* design/irc_ctrl.sv */
`default_nettype none

module irc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               out_ready_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output irc_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_commit;
  logic   accept;

  // the update step finishes only when the output register is free or emptying
  assign can_commit = (state_q == S_UPD) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) || can_commit;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (can_commit) begin
          out_valid_d = 1'b1;
          state_d     = accept ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.load_req = accept;
  assign cmd_o.look     = (state_q == S_LOOK);
  assign cmd_o.commit   = can_commit;

endmodule

`default_nettype wire

/* design/irc_dp.sv */
`default_nettype none

module irc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire irc_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [irc_pkg::DEV_W-1:0]     dev_i,
  input  wire logic [irc_pkg::INUM_W-1:0]    inum_i,
  input  wire logic [irc_pkg::SLOT_W-1:0]    slot_i,
  output logic [irc_pkg::SLOT_W-1:0]         slot_out_o,
  output logic                               hit_o,
  output logic                               loaded_o,
  output logic [irc_pkg::REF_W-1:0]          ref_after_o,
  output logic [1:0]                         status_o
);

  // request registers
  irc_pkg::req_e                 req_q;
  logic [irc_pkg::DEV_W-1:0]     dev_q;
  logic [irc_pkg::INUM_W-1:0]    inum_q;
  logic [irc_pkg::SLOT_W-1:0]    slot_q;

  // tag lanes, live and loaded bits, reference count memory
  logic [irc_pkg::DEV_W-1:0]     tag_dev_q  [irc_pkg::SLOTS];
  logic [irc_pkg::INUM_W-1:0]    tag_inum_q [irc_pkg::SLOTS];
  logic [irc_pkg::SLOTS-1:0]     live_q;
  logic [irc_pkg::SLOTS-1:0]     loaded_q;
  logic [irc_pkg::REF_W-1:0]     refs_mem [irc_pkg::SLOTS];
  logic [irc_pkg::REF_W-1:0]     refs_rd_q;

  // lookup results
  logic [irc_pkg::SLOTS-1:0]     match_v;
  logic [irc_pkg::SLOTS-1:0]     free_v;
  logic [irc_pkg::SLOTS-1:0]     free_first;
  logic [irc_pkg::IDX_W-1:0]     match_idx;
  logic [irc_pkg::IDX_W-1:0]     free_idx;
  logic                          is_get;
  logic                          any_match;
  logic                          any_free;
  logic [irc_pkg::IDX_W-1:0]     sel_idx_d, sel_idx_q;
  logic                          hit_q;
  logic                          full_q;
  logic                          in_range_q;

  // update step
  logic                          cur_live;
  logic [irc_pkg::REF_W-1:0]     refs_cur;
  logic                          cur_loaded;
  logic                          refs_we;
  logic [irc_pkg::REF_W-1:0]     refs_wdata;
  logic                          alloc;
  logic                          set_loaded;
  logic [irc_pkg::SLOT_W-1:0]    res_slot;
  logic                          res_hit;
  logic                          res_loaded;
  logic [irc_pkg::REF_W-1:0]     res_ref;
  irc_pkg::status_e              res_status;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= irc_pkg::req_e'(req_type_i);
      dev_q  <= dev_i;
      inum_q <= inum_i;
      slot_q <= slot_i;
    end
  end

  assign is_get = (req_q == irc_pkg::REQ_GET);

  always_comb begin
    for (int i = 0; i < irc_pkg::SLOTS; i++) begin
      match_v[i] = live_q[i] && (tag_dev_q[i] == dev_q) && (tag_inum_q[i] == inum_q);
    end
  end

  assign free_v     = ~live_q;
  assign free_first = free_v & (~free_v + irc_pkg::SLOTS'(1));
  assign any_match  = |match_v;
  assign any_free   = |free_v;

  // live tags are unique, so at most one lane matches
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < irc_pkg::SLOTS; i++) begin
      if (match_v[i]) begin
        match_idx = match_idx | irc_pkg::IDX_W'(i);
      end
      if (free_first[i]) begin
        free_idx = free_idx | irc_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (is_get) begin
      sel_idx_d = any_match ? match_idx : free_idx;
    end else begin
      sel_idx_d = irc_pkg::IDX_W'(slot_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      sel_idx_q  <= sel_idx_d;
      hit_q      <= is_get && any_match;
      full_q     <= is_get && !any_match && !any_free;
      in_range_q <= (int'(slot_q) < irc_pkg::SLOTS);
      refs_rd_q  <= refs_mem[sel_idx_d];
    end
  end

  assign cur_live   = live_q[sel_idx_q];
  assign refs_cur   = cur_live ? refs_rd_q : '0;
  assign cur_loaded = loaded_q[sel_idx_q];

  always_comb begin
    refs_we    = 1'b0;
    refs_wdata = refs_cur;
    alloc      = 1'b0;
    set_loaded = 1'b0;
    res_slot   = slot_q;
    res_hit    = 1'b0;
    res_loaded = 1'b0;
    res_ref    = '0;
    res_status = irc_pkg::ST_OK;
    case (req_q)
      irc_pkg::REQ_GET: begin
        res_slot = irc_pkg::SLOT_W'(sel_idx_q);
        if (hit_q) begin
          res_hit    = 1'b1;
          res_loaded = cur_loaded;
          if (refs_cur == irc_pkg::REF_MAX) begin
            res_ref    = refs_cur;
            res_status = irc_pkg::ST_SAT;
          end else begin
            refs_we    = 1'b1;
            refs_wdata = refs_cur + irc_pkg::REF_W'(1);
            res_ref    = refs_wdata;
          end
        end else if (full_q) begin
          res_slot   = '0;
          res_status = irc_pkg::ST_FULL;
        end else begin
          alloc      = 1'b1;
          refs_we    = 1'b1;
          refs_wdata = irc_pkg::REF_W'(1);
          res_ref    = refs_wdata;
        end
      end
      irc_pkg::REQ_RELEASE: begin
        if (!in_range_q) begin
          res_status = irc_pkg::ST_REL_ZERO;
        end else if (refs_cur == '0) begin
          res_loaded = cur_loaded;
          res_status = irc_pkg::ST_REL_ZERO;
        end else begin
          refs_we    = 1'b1;
          refs_wdata = refs_cur - irc_pkg::REF_W'(1);
          res_loaded = cur_loaded;
          res_ref    = refs_wdata;
        end
      end
      irc_pkg::REQ_MARK: begin
        if (in_range_q) begin
          set_loaded = 1'b1;
          res_loaded = 1'b1;
          res_ref    = refs_cur;
        end
      end
      default: begin
        if (in_range_q) begin
          res_loaded = cur_loaded;
          res_ref    = refs_cur;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && refs_we) begin
      refs_mem[sel_idx_q] <= refs_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && alloc) begin
      tag_dev_q[sel_idx_q]  <= dev_q;
      tag_inum_q[sel_idx_q] <= inum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= '0;
      loaded_q <= '0;
    end else if (cmd_i.commit) begin
      if (refs_we) begin
        live_q[sel_idx_q] <= (refs_wdata != '0);
      end
      if (alloc) begin
        loaded_q[sel_idx_q] <= 1'b0;
      end else if (set_loaded) begin
        loaded_q[sel_idx_q] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_out_o  <= res_slot;
      hit_o       <= res_hit;
      loaded_o    <= res_loaded;
      ref_after_o <= res_ref;
      status_o    <= res_status;
    end
  end

endmodule

`default_nettype wire

/* design/inode_ref_cache.sv */
// channel  dir  modport  transaction
// req_i    in   sink     one request: req_type, dev, inum, slot
// rsp_o    out  source   one result: slot_out, hit, loaded, ref_after, status
//
// each request passes a look step and an update step: a parallel tag compare across
// all slots and the reference count memory read in the look step, the count update
// and write back in the update step
// a new request is taken in the cycle the previous one finishes
// reset clears the live and loaded bits at once, so every count reads as zero,
// no sweep
// a result waiting on rsp_o holds the next request in its update cycle
`default_nettype none

module inode_ref_cache (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  irc_in_if.sink       req_i,
  irc_out_if.source    rsp_o
);

  irc_pkg::ctrl_cmd_t cmd;

  irc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  irc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (req_i.req_type),
    .dev_i       (req_i.dev),
    .inum_i      (req_i.inum),
    .slot_i      (req_i.slot),
    .slot_out_o  (rsp_o.slot_out),
    .hit_o       (rsp_o.hit),
    .loaded_o    (rsp_o.loaded),
    .ref_after_o (rsp_o.ref_after),
    .status_o    (rsp_o.status)
  );

endmodule

`default_nettype wire
